/* sv/wall_follow_corner_controller_macros.svh */
// Assertion macros for the wall follow corner controller.
`ifndef WALL_FOLLOW_CORNER_CONTROLLER_MACROS_SVH
`define WALL_FOLLOW_CORNER_CONTROLLER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, held off during reset.
`define WFCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, held off during reset.
`define WFCC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WFCC_ASSERT_IMP(label, ante, cons, msg)
`define WFCC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* sv/wfcc_pkg.sv */
// Shared types and constants of the wall follow corner controller.
`timescale 1ns / 1ps
package wfcc_pkg;

  // Operation codes of an input item (code 3 is ignored)
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LASER  = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_FOLLOW   = 3'd0;
  localparam logic [2:0] CFG_SETPOINT = 3'd1;
  localparam logic [2:0] CFG_RISE     = 3'd2;
  localparam logic [2:0] CFG_FLAT     = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT  = 3'd4;

  // Configuration reset values
  localparam logic [15:0] SETPOINT_RST = 16'd700;
  localparam logic [15:0] RISE_RST     = 16'd1300;
  localparam logic [15:0] FLAT_RST     = 16'd300;
  localparam logic [15:0] TIMEOUT_RST  = 16'd15000;

  // Motor and steering commands
  localparam logic [4:0] MOTOR_STOP     = 5'd0;
  localparam logic [4:0] MOTOR_TURN     = 5'd5;
  localparam logic [4:0] MOTOR_STRAIGHT = 5'd10;
  localparam logic [4:0] MOTOR_FOLLOW   = 5'd20;
  localparam logic signed [6:0] STEER_ZERO = 7'sd0;
  localparam logic signed [6:0] STEER_TURN = 7'sd30;
  localparam logic [5:0] STEER_LIMIT = 6'd40;

  // PD gains: steer = -(KP*e*dt + KD*de) / (DT_SCALE*dt)
  localparam logic [19:0] KD_GAIN  = 20'd360000;
  localparam logic [9:0]  DT_SCALE = 10'd1000;

  // Curve timing
  localparam logic [15:0] CURVE_LIMIT_WIN = 16'd200;
  localparam logic [15:0] STRAIGHT_BASE   = 16'd400;
  localparam logic [16:0] TURN_BASE       = 17'd600;
  localparam logic [15:0] RECIP5_Q18      = 16'd52429;   // 2^18/5, exact below 2^18
  localparam logic [16:0] CURVE_Q16       = 17'd103261;  // 9.9/(2*pi) in Q16

  // Divider: one saturation step plus six quotient bits
  localparam int DIV_STEPS = 7;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic err_calc;
    logic mul;
    logic sum;
    logic div_step;
    logic steer_fin;
    logic stop_res;
    logic curve_mul;
    logic curve_lim;
    logic curve_sel;
    logic laser_upd;
    logic tick_upd;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_sample;
    logic is_laser;
    logic is_tick;
    logic follow_en;
    logic curve_done;
    logic out_free;
  } sts_t;

endpackage

/* sv/wfcc_ctrl.sv */
// Sequencing state machine of the wall follow corner controller.
`timescale 1ns / 1ps
module wfcc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wfcc_pkg::sts_t sts_i,
  output wfcc_pkg::cmd_t cmd_o
);
  import wfcc_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DISPATCH = 9'b000000010,
    ST_MUL      = 9'b000000100,
    ST_SUM      = 9'b000001000,
    ST_DIV      = 9'b000010000,
    ST_FIN      = 9'b000100000,
    ST_CLIM     = 9'b001000000,
    ST_CSEL     = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.is_laser) begin
          cmd_o.laser_upd = 1'b1;
          state_d         = ST_IDLE;
        end else if (sts_i.is_tick) begin
          cmd_o.tick_upd = 1'b1;
          state_d        = ST_IDLE;
        end else if (sts_i.is_sample) begin
          if (!sts_i.follow_en) begin
            cmd_o.stop_res = 1'b1;
            state_d        = ST_DONE;
          end else if (sts_i.curve_done) begin
            cmd_o.err_calc = 1'b1;
            state_d        = ST_MUL;
          end else begin
            cmd_o.curve_mul = 1'b1;
            state_d         = ST_CLIM;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        step_d    = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.steer_fin = 1'b1;
        state_d         = ST_DONE;
      end
      ST_CLIM: begin
        cmd_o.curve_lim = 1'b1;
        state_d         = ST_CSEL;
      end
      ST_CSEL: begin
        cmd_o.curve_sel = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

/* sv/wfcc_datapath.sv */
// Datapath: configuration, state, PD math, divider, curve timing, output register.
`timescale 1ns / 1ps
module wfcc_datapath #(
  parameter int unsigned TICK_STEP_MS = 100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wfcc_pkg::cmd_t      cmd_i,
  output wfcc_pkg::sts_t      sts_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [1:0]          operation_i,
  input  logic [15:0]         left_mm_i,
  input  logic [31:0]         now_ms_i,
  input  logic [15:0]         near_range_mm_i,
  input  logic [15:0]         mid_range_mm_i,
  input  logic [15:0]         far_range_mm_i,
  input  logic [12:0]         wall_angle_mrad_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [4:0]          motor_cmd_o,
  output logic signed [6:0]   steer_cmd_o
);
  import wfcc_pkg::*;

  // Configuration registers
  logic        follow_q;
  logic [15:0] setpoint_q, rise_q, flat_q, timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_q   <= 1'b0;
      setpoint_q <= SETPOINT_RST;
      rise_q     <= RISE_RST;
      flat_q     <= FLAT_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FOLLOW:   follow_q   <= cfg_wdata_i[0];
        CFG_SETPOINT: setpoint_q <= cfg_wdata_i;
        CFG_RISE:     rise_q     <= cfg_wdata_i;
        CFG_FLAT:     flat_q     <= cfg_wdata_i;
        CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Captured input item
  logic [1:0]  op_q;
  logic [15:0] left_q, near_q, mid_q, far_q;
  logic [31:0] now_q;
  logic [12:0] angle_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      left_q  <= left_mm_i;
      now_q   <= now_ms_i;
      near_q  <= near_range_mm_i;
      mid_q   <= mid_range_mm_i;
      far_q   <= far_range_mm_i;
      angle_q <= wall_angle_mrad_i;
    end
  end

  // Controller state
  logic signed [16:0] prev_err_q;
  logic [31:0]        prev_time_q;
  logic               curve_done_q;
  logic [15:0]        timer_q;
  logic [15:0]        straight_end_q, turn_end_q;
  logic [12:0]        stored_angle_q;

  // Error, error change and time step
  logic signed [16:0] err;
  logic signed [17:0] derr;
  logic [31:0]        dt;
  logic [31:0]        mval;

  always_comb begin
    err  = $signed({1'b0, setpoint_q}) - $signed({1'b0, left_q});
    derr = 18'(err) - 18'(prev_err_q);
    dt   = now_q - prev_time_q;
    // zero step: proportional term alone when de is zero, else a zero divisor saturates
    mval = (dt == 32'd0) ? {31'd0, (derr == 18'sd0)} : dt;
  end

  logic signed [16:0] e_q;
  logic signed [17:0] de_q;
  logic [31:0]        m_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_calc) begin
      e_q  <= err;
      de_q <= derr;
      m_q  <= mval;
    end
  end

  // Products of the PD terms and the divisor
  logic signed [22:0] e36;
  logic signed [55:0] p1_q;
  logic signed [37:0] p2_q;
  logic [41:0]        d_q;

  assign e36 = (23'(e_q) <<< 5) + (23'(e_q) <<< 2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p1_q <= 56'(e36) * $signed({24'd0, m_q});
      p2_q <= 38'(de_q) * $signed({18'd0, KD_GAIN});
      d_q  <= 42'(m_q) * 42'(DT_SCALE);
    end
  end

  // Sum and magnitude, then restoring division over seven steps
  logic signed [56:0] a_sum;
  logic [55:0]        a_mag;
  logic               a_neg_q;
  logic [55:0]        rem_q;
  logic [47:0]        dsh_q;
  logic [6:0]         quo_q;
  logic               div_ge;

  always_comb begin
    a_sum  = 57'(p1_q) + 57'(p2_q);
    a_mag  = a_sum[56] ? 56'(-a_sum) : 56'(a_sum);
    div_ge = (rem_q >= {8'd0, dsh_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      a_neg_q <= a_sum[56];
      rem_q   <= a_mag;
      dsh_q   <= {d_q, 6'd0};
      quo_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - {8'd0, dsh_q};
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[5:0], div_ge};
    end
  end

  // Clamp and sign: the result is -A/D, truncated toward zero
  logic [5:0]        steer_mag;
  logic signed [6:0] steer_pd;

  always_comb begin
    steer_mag = (quo_q[6] || (quo_q[5:0] > STEER_LIMIT)) ? STEER_LIMIT : quo_q[5:0];
    steer_pd  = a_neg_q ? $signed({1'b0, steer_mag}) : -$signed({1'b0, steer_mag});
  end

  // Curve limit products, turn length from the latched wall angle
  logic [33:0] ps_q;
  logic [29:0] pa_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.curve_mul) begin
      ps_q <= 34'({left_q, 2'b00}) * 34'(RECIP5_Q18);
      pa_q <= 30'(stored_angle_q) * 30'(CURVE_Q16);
    end
  end

  logic [15:0] straight_new;
  logic [16:0] turn_sum;
  logic [15:0] turn_new;

  always_comb begin
    straight_new = STRAIGHT_BASE + ps_q[33:18];
    turn_sum     = 17'(straight_new) + TURN_BASE + 17'(pa_q[29:16]);
    turn_new     = turn_sum[16] ? 16'hFFFF : turn_sum[15:0];
  end

  // Laser corner test on signed range differences
  logic signed [16:0] rise_diff, flat_diff;
  logic               corner;

  always_comb begin
    rise_diff = $signed({1'b0, far_q}) - $signed({1'b0, mid_q});
    flat_diff = $signed({1'b0, mid_q}) - $signed({1'b0, near_q});
    corner    = (rise_diff > $signed({1'b0, rise_q})) &&
                (flat_diff < $signed({1'b0, flat_q}));
  end

  // Timer tick with saturation
  logic [16:0] tick_sum;
  assign tick_sum = 17'(timer_q) + 17'(TICK_STEP_MS);

  // State updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q     <= '0;
      prev_time_q    <= '0;
      curve_done_q   <= 1'b1;
      timer_q        <= '0;
      straight_end_q <= '0;
      turn_end_q     <= '0;
    end else begin
      if (cmd_i.err_calc) begin
        prev_err_q  <= err;
        prev_time_q <= now_q;
        timer_q     <= '0;
      end
      if (cmd_i.curve_lim && (timer_q < CURVE_LIMIT_WIN)) begin
        straight_end_q <= straight_new;
        turn_end_q     <= turn_new;
      end
      if (cmd_i.curve_sel && (timer_q >= straight_end_q) && (timer_q >= turn_end_q)) begin
        timer_q      <= '0;
        curve_done_q <= 1'b1;
      end
      if (cmd_i.laser_upd && curve_done_q && corner) begin
        curve_done_q <= 1'b0;
      end
      if (cmd_i.tick_upd && !curve_done_q) begin
        if (timer_q >= timeout_q) begin
          timer_q      <= '0;
          curve_done_q <= 1'b1;
        end else begin
          timer_q <= tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
        end
      end
    end
  end

  // Wall angle latch, only outside a curve
  always_ff @(posedge clk_i) begin
    if (cmd_i.laser_upd && curve_done_q) begin
      stored_angle_q <= angle_q;
    end
  end

  // Result register
  logic [4:0]        res_motor_q;
  logic signed [6:0] res_steer_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.stop_res) begin
      res_motor_q <= MOTOR_STOP;
      res_steer_q <= STEER_ZERO;
    end else if (cmd_i.steer_fin) begin
      res_motor_q <= MOTOR_FOLLOW;
      res_steer_q <= steer_pd;
    end else if (cmd_i.curve_sel) begin
      if (timer_q < straight_end_q) begin
        res_motor_q <= MOTOR_STRAIGHT;
        res_steer_q <= STEER_ZERO;
      end else if (timer_q < turn_end_q) begin
        res_motor_q <= MOTOR_TURN;
        res_steer_q <= STEER_TURN;
      end else begin
        res_motor_q <= MOTOR_STRAIGHT;
        res_steer_q <= STEER_ZERO;
      end
    end
  end

  // Output register; a transfer frees it
  logic              out_valid_q;
  logic [4:0]        out_motor_q;
  logic signed [6:0] out_steer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_motor_q <= res_motor_q;
      out_steer_q <= res_steer_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign motor_cmd_o = out_motor_q;
  assign steer_cmd_o = out_steer_q;

  // Status to the controller
  always_comb begin
    sts_o.is_sample  = (op_q == OP_SAMPLE);
    sts_o.is_laser   = (op_q == OP_LASER);
    sts_o.is_tick    = (op_q == OP_TICK);
    sts_o.follow_en  = follow_q;
    sts_o.curve_done = curve_done_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

/* sv/wall_follow_corner_controller.sv */
// Top level of the wall follow corner controller.
`timescale 1ns / 1ps
// Car controller in mm, mrad and ms. One item is worked at a time. A sensor sample in
// wall follow mode gets its PD quotient from a restoring divider that settles one bit per
// cycle over seven steps (a saturation bit and six quotient bits), behind the registered
// error, products and sum. A sample during a corner curve passes the curve products,
// the curve limit and the curve selection, a sample with follow off loads a stop result,
// and a laser event or timer tick ends with no result.
// The result sits in an output register, so the next item is taken while it waits.
// Configuration writes take effect at once and belong to idle periods.
`include "wall_follow_corner_controller_macros.svh"
module wall_follow_corner_controller #(
  parameter int unsigned TICK_STEP_MS = 100
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [15:0]       left_mm_i,
  input  logic [31:0]       now_ms_i,
  input  logic [15:0]       near_range_mm_i,
  input  logic [15:0]       mid_range_mm_i,
  input  logic [15:0]       far_range_mm_i,
  input  logic [12:0]       wall_angle_mrad_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [4:0]        motor_cmd_o,
  output logic signed [6:0] steer_cmd_o
);
  import wfcc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wfcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wfcc_datapath #(
    .TICK_STEP_MS (TICK_STEP_MS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .operation_i       (operation_i),
    .left_mm_i         (left_mm_i),
    .now_ms_i          (now_ms_i),
    .near_range_mm_i   (near_range_mm_i),
    .mid_range_mm_i    (mid_range_mm_i),
    .far_range_mm_i    (far_range_mm_i),
    .wall_angle_mrad_i (wall_angle_mrad_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .motor_cmd_o       (motor_cmd_o),
    .steer_cmd_o       (steer_cmd_o)
  );

  // Legal output values
  logic steer_ok;
  logic motor_ok;

  assign steer_ok = (steer_cmd_o <= 7'sd40) && (steer_cmd_o >= -7'sd40);
  assign motor_ok = (motor_cmd_o == MOTOR_STOP) || (motor_cmd_o == MOTOR_TURN) ||
                    (motor_cmd_o == MOTOR_STRAIGHT) || (motor_cmd_o == MOTOR_FOLLOW);

  // Checks
  `WFCC_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
  `WFCC_ASSERT_NXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "ready after transfer")
  `WFCC_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free, "output register overwritten")
  `WFCC_ASSERT_IMP(a_steer_range, out_valid_o, steer_ok, "steering out of range")
  `WFCC_ASSERT_IMP(a_motor_code, out_valid_o, motor_ok, "bad motor level")

endmodule
